@@ hdl/stable_priority_queue_defines.svh @@
// assertion macros for the stable priority queue
// each macro expects clk and rst_n in the scope where it is used
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTH

// consequent must hold in the same cycle as the antecedent
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SPQ_ASSERT_NOW(lbl, ante, cons, msg)
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ hdl/spq_pkg.sv @@
package spq_pkg;

  // queue sizing
  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_BITS    = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_EMPTY  = 2'd2
  } status_t;

  // input request payload
  typedef struct packed {
    logic               req_type;
    logic [15:0]        item_tag;
    logic [7:0]         item_kind;
    logic signed [15:0] item_priority;
  } spq_in_t;

  // result payload
  typedef struct packed {
    status_t            status;
    logic [4:0]         entry_total;
    logic [15:0]        out_tag;
    logic [7:0]         out_kind;
    logic signed [15:0] out_priority;
  } spq_out_t;

  // one queued entry
  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [7:0]          kind;
    logic signed [15:0]  prio;
  } entry_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t ent;
  } spq_ctl_t;

endpackage

@@ hdl/stable_priority_queue.sv @@
// channel  direction  ports                          transfer when
// in       input      in_valid, in_ready, in_data    in_valid && in_ready
// out      output     out_valid, out_ready, out_data out_valid && out_ready
//
// one request per cycle: the cell chain compares all entries in parallel and
// shifts on the same edge that loads the result register
// a request is taken while a result waits if out_ready is high in that cycle
// out_ready low with a result held stalls the input side
// synchronous active-low reset empties the queue; entry storage is not cleared
module stable_priority_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  spq_pkg::spq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output spq_pkg::spq_out_t out_data
);
  import spq_pkg::*;
  `include "stable_priority_queue_defines.svh"

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r;
  spq_out_t         out_data_r, res_nxt;

  entry_t                 cell_ent [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_gt, cell_match, cell_valid;
  entry_t                 new_ent;
  spq_ctl_t               ctl;
  logic                   in_fire, is_ins, is_rem, full, dup, ins_ok, rem_ok;

  // handshake
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // request decode
  assign new_ent.tag  = TAG_BITS'(in_data.item_tag);
  assign new_ent.kind = in_data.item_kind;
  assign new_ent.prio = in_data.item_priority;
  assign is_ins = (in_data.req_type == REQ_INSERT);
  assign is_rem = (in_data.req_type == REQ_REMOVE);
  assign full   = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign dup    = |cell_match;
  assign ins_ok = is_ins && (new_ent.tag != '0) && !full && !dup;
  assign rem_ok = is_rem && (cnt_r != '0);

  assign ctl.ins = in_fire && rst_n && ins_ok;
  assign ctl.rem = in_fire && rst_n && rem_ok;
  assign ctl.ent = new_ent;

  // cell chain
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign cell_valid[i] = (cnt_r > CNT_W'(i));
    spq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .left_ent  ((i == 0) ? new_ent : cell_ent[(i == 0) ? 0 : i - 1]),
      .left_gt   ((i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i - 1]),
      .right_ent ((i == QUEUE_DEPTH - 1) ? cell_ent[i]
                  : cell_ent[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
      .valid     (cell_valid[i]),
      .ent       (cell_ent[i]),
      .gt        (cell_gt[i]),
      .match     (cell_match[i])
    );
  end

  // next count and result
  always_comb begin
    cnt_nxt = cnt_r;
    res_nxt.status       = ST_OK;
    res_nxt.out_tag      = '0;
    res_nxt.out_kind     = '0;
    res_nxt.out_priority = '0;
    if (is_ins) begin
      if (ins_ok) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end else begin
        res_nxt.status = ST_REJECT;
      end
    end else if (rem_ok) begin
      cnt_nxt              = cnt_r - CNT_W'(1);
      res_nxt.out_tag      = 16'(cell_ent[0].tag);
      res_nxt.out_kind     = cell_ent[0].kind;
      res_nxt.out_priority = cell_ent[0].prio;
    end else begin
      res_nxt.status = ST_EMPTY;
    end
    res_nxt.entry_total = 5'(cnt_nxt);
  end

  // count, result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        cnt_r       <= cnt_nxt;
        out_data_r  <= res_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // checks
  `SPQ_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(QUEUE_DEPTH), "count exceeds depth")
  `SPQ_ASSERT_NEXT(a_ins_count, ctl.ins, cnt_r == $past(cnt_r) + CNT_W'(1), "insert miscount")
  `SPQ_ASSERT_NEXT(a_rem_head, ctl.rem, out_data_r.out_tag == 16'($past(cell_ent[0].tag)), "bad head")
  `SPQ_ASSERT_NOW(a_one_match, 1'b1, $onehot0(cell_match), "tag queued twice")

  for (genvar j = 1; j < QUEUE_DEPTH; j++) begin : g_chk
    `SPQ_ASSERT_NOW(a_sorted, cell_valid[j], cell_ent[j-1].prio <= cell_ent[j].prio, "unsorted")
  end

endmodule

@@ hdl/spq_cell.sv @@
module spq_cell (
  input  logic            clk,
  input  spq_pkg::spq_ctl_t ctl,
  input  spq_pkg::entry_t left_ent,
  input  logic            left_gt,
  input  spq_pkg::entry_t right_ent,
  input  logic            valid,
  output spq_pkg::entry_t ent,
  output logic            gt,
  output logic            match
);
  import spq_pkg::*;

  entry_t ent_r;

  // empty cells count as greater so a new entry lands at the tail
  assign gt    = !valid || (ent_r.prio > ctl.ent.prio);
  assign match = valid && (ent_r.tag == ctl.ent.tag);
  assign ent   = ent_r;

  // insert: boundary cell takes the new entry, cells behind it shift right
  // remove: every cell takes its right neighbor; the last cell keeps its own entry
  always_ff @(posedge clk) begin
    if (ctl.ins && gt) begin
      ent_r <= left_gt ? left_ent : ctl.ent;
    end else if (ctl.rem) begin
      ent_r <= right_ent;
    end
  end

endmodule
